// File: rtl/pcdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdq_pkg
// Shared types, constants and tables for the phase current to dq converter.
// ----------------------------------------------------------------------------
package pcdq_pkg;

  localparam int unsigned CAL_ROUNDS_DEF   = 500;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned CODE_W  = 13;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned CUR_W   = 16;
  localparam int unsigned DQ_W    = 18;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned CNT_W   = 9;

  localparam int unsigned STEP_W    = 5;
  localparam int unsigned DIV_W     = 26;
  localparam int unsigned DIV_STEPS = 6;
  localparam int unsigned CS_W      = 34;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 50;

  localparam int unsigned RCP_SHIFT  = 35;
  localparam int unsigned RCP_W      = 36;
  localparam int unsigned RCP_PART   = 18;
  localparam int unsigned RCP_PROD_W = DIV_W + RCP_PART;
  localparam int unsigned RCP_FULL_W = DIV_W + RCP_W;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic        REG_IDX_GAIN = 1'b0;

  localparam logic [19:0] RECIP5    = 20'd838861;
  localparam logic [19:0] RECIP3    = 20'd699051;
  localparam logic [15:0] INV_SQRT3 = 16'd37837;
  localparam logic [31:0] CORDIC_K  = 32'd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROT,
    ST_ALPHA,
    ST_BETA,
    ST_PARK,
    ST_ACC,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } pcdq_state_e;

  typedef enum logic [1:0] {
    MUL_PHASE,
    MUL_ALPHA,
    MUL_BETA,
    MUL_PARK
  } pcdq_mul_e;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    pcdq_mul_e         mul_op;
    logic [1:0]        sel;
    logic              rot;
    logic [STEP_W-1:0] step;
    logic              div_load;
    logic              div_step;
    logic              commit;
    logic              out_load;
  } pcdq_cmd_t;

  typedef struct packed {
    logic cal_pend;
    logic out_free;
  } pcdq_stat_t;

  function automatic logic [31:0] atan_lookup(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335086;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20860;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2607;
      5'd19:   v = 32'd1303;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pcdq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdq_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pcdq_in_if import pcdq_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [CODE_W-1:0]   code_a;
  logic signed [CODE_W-1:0]   code_b;
  logic signed [CODE_W-1:0]   code_c;
  logic        [ANGLE_W-1:0]  electrical_angle;

  modport source (output valid, cmd, code_a, code_b, code_c, electrical_angle,
                  input ready);
  modport sink (input valid, cmd, code_a, code_b, code_c, electrical_angle,
                output ready);
endinterface

interface pcdq_out_if import pcdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CUR_W-1:0]  current_a;
  logic signed [CUR_W-1:0]  current_b;
  logic signed [CUR_W-1:0]  current_c;
  logic signed [DQ_W-1:0]   d_current;
  logic signed [DQ_W-1:0]   q_current;
  logic                     cal_done;
  logic        [OFS_W-1:0]  offset_a_out;
  logic        [OFS_W-1:0]  offset_b_out;
  logic        [OFS_W-1:0]  offset_c_out;

  modport source (output valid, current_a, current_b, current_c, d_current, q_current,
                  cal_done, offset_a_out, offset_b_out, offset_c_out, input ready);
  modport sink (input valid, current_a, current_b, current_c, d_current, q_current,
                cal_done, offset_a_out, offset_b_out, offset_c_out, output ready);
endinterface
`default_nettype wire

// File: rtl/pcdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdq_ctrl
// Sequencer that steps the datapath through conversion, rotation and offset
// calibration for one item at a time.
// ----------------------------------------------------------------------------
module pcdq_ctrl import pcdq_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pcdq_stat_t stat_i,
  output pcdq_cmd_t  cmd_o
);

  pcdq_state_e       state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (cnt_q == STEP_W'(2)) begin
          state_d = ST_ROT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_ROT: begin
        if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_ALPHA;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_ALPHA: state_d = ST_BETA;
      ST_BETA: begin
        state_d = ST_PARK;
        cnt_d   = '0;
      end
      ST_PARK: begin
        if (cnt_q == STEP_W'(3)) begin
          state_d = ST_ACC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_ACC: begin
        cnt_d   = '0;
        state_d = stat_i.cal_pend ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_COMMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = MUL_PHASE;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PHASE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_PHASE;
        cmd_o.sel    = cnt_q[1:0];
      end
      ST_ROT: begin
        cmd_o.rot  = 1'b1;
        cmd_o.step = cnt_q;
      end
      ST_ALPHA: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_ALPHA;
      end
      ST_BETA: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_BETA;
      end
      ST_PARK: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_PARK;
        cmd_o.sel    = cnt_q[1:0];
      end
      ST_ACC:    cmd_o.div_load = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.step     = cnt_q;
      end
      ST_COMMIT: cmd_o.commit   = 1'b1;
      ST_OUT:    cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pcdq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdq_dp
// Datapath: offset removal and scaling, Clarke and Park through one shared
// multiplier, iterative CORDIC, calibration sums and offset divider.
// ----------------------------------------------------------------------------
module pcdq_dp import pcdq_pkg::*; #(
  parameter int unsigned CAL_ROUNDS = CAL_ROUNDS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      gain_i,
  input  logic                      cmd_i,
  input  logic signed [CODE_W-1:0]  code_a_i,
  input  logic signed [CODE_W-1:0]  code_b_i,
  input  logic signed [CODE_W-1:0]  code_c_i,
  input  logic        [ANGLE_W-1:0] angle_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [CUR_W-1:0]   current_a_o,
  output logic signed [CUR_W-1:0]   current_b_o,
  output logic signed [CUR_W-1:0]   current_c_o,
  output logic signed [DQ_W-1:0]    d_current_o,
  output logic signed [DQ_W-1:0]    q_current_o,
  output logic                      cal_done_o,
  output logic        [OFS_W-1:0]   offset_a_o,
  output logic        [OFS_W-1:0]   offset_b_o,
  output logic        [OFS_W-1:0]   offset_c_o,
  input  pcdq_cmd_t                 ctl_i,
  output pcdq_stat_t                stat_o
);

  localparam logic [DIV_W-1:0] HALF_R = DIV_W'(CAL_ROUNDS / 2);
  localparam longint unsigned RCP_L = ((64'd1 << RCP_SHIFT) + 64'(CAL_ROUNDS) - 64'd1)
                                      / 64'(CAL_ROUNDS);
  localparam logic [RCP_W-1:0] RECIP_R = RCP_W'(RCP_L);

  function automatic logic [ADC_W-1:0] clamp_code(input logic signed [CODE_W-1:0] c);
    return c[CODE_W-1] ? '0 : c[ADC_W-1:0];
  endfunction

  function automatic logic signed [DQ_W-1:0] sat_dq(input logic signed [19:0] v);
    logic signed [DQ_W-1:0] r;
    if (v > 20'sd131071) begin
      r = 18'sd131071;
    end else if (v < -20'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[DQ_W-1:0];
    end
    return r;
  endfunction

  // state
  logic [OFS_W-1:0] offs_q [3];
  logic [SUM_W-1:0] sums_q [3];
  logic [CNT_W-1:0] count_q;
  logic             pend_q;
  logic             out_valid_q;
  logic             mul_en_q;

  // payload
  logic        [ADC_W-1:0]  code_q [3];
  logic signed [CUR_W-1:0]  cur_q [3];
  logic signed [DQ_W-1:0]   alpha_q, beta_q;
  logic signed [CS_W-1:0]   x_q, y_q, z_q;
  logic                     flip_q;
  logic signed [PROD_W-1:0] prod_q;
  pcdq_mul_e                mul_op_q;
  logic [1:0]               sel_q;
  logic signed [ACC_W-1:0]  accd_q, accq_q;
  logic [DIV_W-1:0]         num_q [3];
  logic [RCP_PROD_W-1:0]    dv_lo_q;
  logic signed [CUR_W-1:0]  o_cur_q [3];
  logic signed [DQ_W-1:0]   o_d_q, o_q_q;
  logic                     o_done_q;
  logic [OFS_W-1:0]         o_ofs_q [3];

  // load-time values
  logic [ADC_W-1:0]       code_in [3];
  logic signed [31:0]     z_raw;
  logic signed [CS_W-1:0] z_ext, z_init;
  logic                   flip_init;
  logic [CNT_W-1:0]       count_inc;

  always_comb begin
    code_in[0] = clamp_code(code_a_i);
    code_in[1] = clamp_code(code_b_i);
    code_in[2] = clamp_code(code_c_i);
    z_raw      = $signed({angle_i, 16'h0000});
    z_ext      = CS_W'(z_raw);
    count_inc  = count_q + CNT_W'(1);
    if (z_ext > 34'sd1073741824) begin
      z_init    = z_ext - 34'sd2147483648;
      flip_init = 1'b1;
    end else if (z_ext < -34'sd1073741824) begin
      z_init    = z_ext + 34'sd2147483648;
      flip_init = 1'b1;
    end else begin
      z_init    = z_ext;
      flip_init = 1'b0;
    end
  end

  // multiplier operands
  logic signed [17:0]     ph_d;
  logic signed [21:0]     ph_n, ph_qb;
  logic signed [18:0]     al_num;
  logic signed [20:0]     al_qb;
  logic signed [16:0]     be_diff;
  logic signed [CS_W-1:0] ct_w, st_w;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d;

  always_comb begin
    ph_d    = $signed({2'b00, code_q[ctl_i.sel], 4'b0000})
            - $signed({2'b00, offs_q[ctl_i.sel]});
    ph_n    = 22'(ph_d) * 22'sd9 + 22'sd10;
    ph_qb   = (ph_n >>> 2) + 22'sd163840;
    al_num  = (19'(cur_q[0]) <<< 1) - 19'(cur_q[1]) - 19'(cur_q[2]) + 19'sd1;
    al_qb   = 21'(al_num) + 21'sd393216;
    be_diff = 17'(cur_q[1]) - 17'(cur_q[2]);
    ct_w    = flip_q ? -x_q : x_q;
    st_w    = flip_q ? -y_q : y_q;
    mul_a   = '0;
    mul_b   = '0;
    unique case (ctl_i.mul_op)
      MUL_PHASE: begin
        mul_a = 32'(ph_qb);
        mul_b = $signed({12'h000, RECIP5});
      end
      MUL_ALPHA: begin
        mul_a = 32'(al_qb);
        mul_b = $signed({12'h000, RECIP3});
      end
      MUL_BETA: begin
        mul_a = 32'(be_diff);
        mul_b = $signed({16'h0000, INV_SQRT3});
      end
      MUL_PARK: begin
        unique case (ctl_i.sel)
          2'd0: begin
            mul_a = 32'(alpha_q);
            mul_b = ct_w[MUL_W-1:0];
          end
          2'd1: begin
            mul_a = 32'(beta_q);
            mul_b = st_w[MUL_W-1:0];
          end
          2'd2: begin
            mul_a = 32'(beta_q);
            mul_b = ct_w[MUL_W-1:0];
          end
          default: begin
            mul_a = 32'(alpha_q);
            mul_b = st_w[MUL_W-1:0];
          end
        endcase
      end
      default: ;
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // product post-processing
  logic signed [17:0]      ph_m, ph_g;
  logic signed [CUR_W-1:0] ph_cur;
  logic signed [20:0]      al_res;
  logic signed [PROD_W-1:0] be_sum, be_res;
  logic signed [ACC_W-1:0] prod_acc;

  always_comb begin
    ph_m = $signed({1'b0, prod_q[38:22]}) - 18'sd32768;
    ph_g = gain_i ? -ph_m : ph_m;
    if (ph_g > 18'sd32767) begin
      ph_cur = 16'sd32767;
    end else if (ph_g < -18'sd32768) begin
      ph_cur = -16'sd32768;
    end else begin
      ph_cur = ph_g[CUR_W-1:0];
    end
    al_res   = $signed({2'b00, prod_q[39:21]}) - 21'sd131072;
    be_sum   = prod_q + 64'sd32768;
    be_res   = be_sum >>> 16;
    prod_acc = prod_q[ACC_W-1:0];
  end

  // CORDIC step
  logic signed [CS_W-1:0] sh_x, sh_y, at_w;
  always_comb begin
    sh_x = x_q >>> ctl_i.step;
    sh_y = y_q >>> ctl_i.step;
    at_w = $signed({2'b00, atan_lookup(ctl_i.step)});
  end

  // offset division by reciprocal: two partial products per phase
  logic [1:0]            dv_idx;
  logic [DIV_W-1:0]      dv_num;
  logic [RCP_PART-1:0]   dv_rcp;
  logic [RCP_PROD_W-1:0] dv_prod;
  logic [RCP_FULL_W-1:0] dv_full;
  logic [DIV_W-1:0]      dv_quo;
  always_comb begin
    dv_idx = ctl_i.step[2:1];
    unique case (dv_idx)
      2'd0:    dv_num = num_q[0];
      2'd1:    dv_num = num_q[1];
      default: dv_num = num_q[2];
    endcase
    dv_rcp  = ctl_i.step[0] ? RECIP_R[RCP_W-1:RCP_PART] : RECIP_R[RCP_PART-1:0];
    dv_prod = RCP_PROD_W'(dv_num) * RCP_PROD_W'(dv_rcp);
    dv_full = {dv_prod, {RCP_PART{1'b0}}} + RCP_FULL_W'(dv_lo_q);
    dv_quo  = DIV_W'(dv_full >> RCP_SHIFT);
  end

  // final rounding of dq
  logic signed [ACC_W-1:0] rd_d, rd_q;
  logic signed [19:0]      id_w, iq_w;
  always_comb begin
    rd_d = accd_q + 50'sd536870912;
    rd_q = accq_q + 50'sd536870912;
    id_w = 20'(rd_d >>> 30);
    iq_w = 20'(rd_q >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        offs_q[i] <= '0;
        sums_q[i] <= '0;
      end
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mul_en_q    <= 1'b0;
    end else begin
      mul_en_q <= ctl_i.mul_en;
      if (ctl_i.load) begin
        if (cmd_i) begin
          for (int i = 0; i < 3; i++) begin
            sums_q[i] <= sums_q[i] + SUM_W'(code_in[i]);
          end
          count_q <= count_inc;
          pend_q  <= count_inc >= CNT_W'(CAL_ROUNDS);
        end else begin
          pend_q <= 1'b0;
        end
      end
      if (ctl_i.commit) begin
        for (int i = 0; i < 3; i++) begin
          offs_q[i] <= (|num_q[i][DIV_W-1:OFS_W]) ? '1 : num_q[i][OFS_W-1:0];
          sums_q[i] <= '0;
        end
        count_q <= '0;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < 3; i++) begin
        code_q[i] <= code_in[i];
      end
      x_q    <= $signed({2'b00, CORDIC_K});
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip_init;
    end
    if (ctl_i.rot) begin
      if (!z_q[CS_W-1]) begin
        x_q <= x_q - sh_y;
        y_q <= y_q + sh_x;
        z_q <= z_q - at_w;
      end else begin
        x_q <= x_q + sh_y;
        y_q <= y_q - sh_x;
        z_q <= z_q + at_w;
      end
    end
    prod_q   <= prod_d;
    mul_op_q <= ctl_i.mul_op;
    sel_q    <= ctl_i.sel;
    if (mul_en_q) begin
      unique case (mul_op_q)
        MUL_PHASE: cur_q[sel_q] <= ph_cur;
        MUL_ALPHA: alpha_q <= al_res[DQ_W-1:0];
        MUL_BETA:  beta_q <= be_res[DQ_W-1:0];
        MUL_PARK: begin
          unique case (sel_q)
            2'd0:    accd_q <= prod_acc;
            2'd1:    accd_q <= accd_q + prod_acc;
            2'd2:    accq_q <= prod_acc;
            default: accq_q <= accq_q - prod_acc;
          endcase
        end
        default: ;
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      if (ctl_i.div_load) begin
        num_q[i] <= {sums_q[i], 4'b0000} + HALF_R;
      end else if (ctl_i.div_step && ctl_i.step[0] && (dv_idx == 2'(i))) begin
        num_q[i] <= dv_quo;
      end
    end
    if (ctl_i.div_step && !ctl_i.step[0]) begin
      dv_lo_q <= dv_prod;
    end
    if (ctl_i.out_load) begin
      for (int i = 0; i < 3; i++) begin
        o_cur_q[i] <= cur_q[i];
        o_ofs_q[i] <= offs_q[i];
      end
      o_d_q    <= sat_dq(id_w);
      o_q_q    <= sat_dq(iq_w);
      o_done_q <= pend_q;
    end
  end

  assign stat_o.cal_pend = pend_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign current_a_o = o_cur_q[0];
  assign current_b_o = o_cur_q[1];
  assign current_c_o = o_cur_q[2];
  assign d_current_o = o_d_q;
  assign q_current_o = o_q_q;
  assign cal_done_o  = o_done_q;
  assign offset_a_o  = o_ofs_q[0];
  assign offset_b_o  = o_ofs_q[1];
  assign offset_c_o  = o_ofs_q[2];

endmodule
`default_nettype wire

// File: rtl/phase_current_to_dq_with_offset_cal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phase_current_to_dq_with_offset_cal
// Three-shunt phase currents to dq with offset calibration.
// ----------------------------------------------------------------------------
// From acceptance to the next acceptance an item passes through three phase
// scalings, one CORDIC iteration per cycle for the sine and cosine, then
// Clarke and four Park products on a single shared 32x32 multiplier. The
// result sits in an output register, so the next item is taken while it
// waits. The item that completes calibration adds the offset division by
// CAL_ROUNDS, a reciprocal multiplication done as two 26x18 partial products
// per phase, then a commit. gain_negative lives at byte address 0.
module phase_current_to_dq_with_offset_cal import pcdq_pkg::*; #(
  parameter int unsigned CAL_ROUNDS   = CAL_ROUNDS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcdq_in_if.sink            in_i,
  pcdq_out_if.source         out_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [ADDR_W-1:0]  paddr_i,
  input  logic [DATA_W-1:0]  pwdata_i,
  output logic [DATA_W-1:0]  prdata_o,
  output logic               pready_o
);

  logic       gain_q;
  logic       reg_idx;
  pcdq_cmd_t  ctl;
  pcdq_stat_t stat;

  assign reg_idx  = paddr_i[ADDR_W-1];
  assign pready_o = 1'b1;
  assign prdata_o = (reg_idx == REG_IDX_GAIN) ? DATA_W'(gain_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && (reg_idx == REG_IDX_GAIN)) begin
      gain_q <= pwdata_i[0];
    end
  end

  pcdq_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (ctl)
  );

  pcdq_dp #(
    .CAL_ROUNDS(CAL_ROUNDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_i     (gain_q),
    .cmd_i      (in_i.cmd),
    .code_a_i   (in_i.code_a),
    .code_b_i   (in_i.code_b),
    .code_c_i   (in_i.code_c),
    .angle_i    (in_i.electrical_angle),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .current_a_o(out_o.current_a),
    .current_b_o(out_o.current_b),
    .current_c_o(out_o.current_c),
    .d_current_o(out_o.d_current),
    .q_current_o(out_o.q_current),
    .cal_done_o (out_o.cal_done),
    .offset_a_o (out_o.offset_a_out),
    .offset_b_o (out_o.offset_b_out),
    .offset_c_o (out_o.offset_c_out),
    .ctl_i      (ctl),
    .stat_o     (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken twice in a row");

  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> in_i.ready)
    else $error("result issued while an item is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !$rose(out_o.valid))
    else $error("result appeared right after acceptance");

endmodule
`default_nettype wire
